/* design/fcsg_pkg.sv */
// Shared types and constants for the filled circle span generator.
`default_nettype none
package fcsg_pkg;

  localparam int unsigned MAX_RADIUS = 20;
  localparam logic [10:0] MAP_LIMIT  = 11'd1024;

  localparam logic [1:0] CFG_RADIUS     = 2'd0;
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] span_start;
    logic [9:0] span_end;
    logic       span_valid;
  } span_t;

  typedef struct packed {
    logic [9:0]  cx;
    logic [9:0]  cy;
    logic [4:0]  row_ofs;
    logic        row_down;
    logic [4:0]  half_len;
    logic [10:0] width;
    logic [10:0] height;
  } span_req_t;

endpackage
`default_nettype wire

/* design/fcsg_span.sv */
// Span unit: forms one horizontal span around the center and clips it to the map.
`default_nettype none
module fcsg_span (
  input  fcsg_pkg::span_req_t req,
  output fcsg_pkg::span_t     span
);

  logic signed [11:0] row_s;
  logic signed [11:0] xs;
  logic signed [11:0] xe;
  logic signed [11:0] xs_c;
  logic signed [11:0] xe_c;
  logic signed [11:0] w_m1;
  logic signed [11:0] h_s;
  logic               ok;

  always_comb begin
    w_m1  = $signed({1'b0, req.width}) - 12'sd1;
    h_s   = $signed({1'b0, req.height});
    row_s = req.row_down ? $signed({2'b00, req.cy}) + $signed({7'd0, req.row_ofs})
                         : $signed({2'b00, req.cy}) - $signed({7'd0, req.row_ofs});
    xs    = $signed({2'b00, req.cx}) - $signed({7'd0, req.half_len});
    xe    = $signed({2'b00, req.cx}) + $signed({7'd0, req.half_len});
    xs_c  = (xs < 12'sd0) ? 12'sd0 : xs;
    xe_c  = (xe > w_m1) ? w_m1 : xe;
    ok    = (row_s >= 12'sd0) && (row_s < h_s) && (req.width != 11'd0) && (xs_c <= xe_c);
    if (ok) begin
      span.row        = row_s[9:0];
      span.span_start = xs_c[9:0];
      span.span_end   = xe_c[9:0];
      span.span_valid = 1'b1;
    end else begin
      span = '0;
    end
  end

endmodule
`default_nettype wire

/* design/filled_circle_span_generator.sv */
// Top level: midpoint circle sequencer that emits clipped filled spans per center.
//
//   port group   dir  contents
//   cfg_*        in   register write: 0 radius, 1 map_width, 2 map_height
//   s_*          in   crater center; tuser marks a solid center cell
//   m_*          out  one span per item; tuser is span_valid, tlast ends the center
//
// A blank center answers with one item. A solid center runs
// the circle loop with one span unit, four spans per step, one span per cycle
// after the accept cycle while the output is not stalled.
// A stalled output holds the sequencer in place. Reset is synchronous and
// restores the register defaults.
`default_nettype none
module filled_circle_span_generator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,  // center_x [9:0], center_y [19:10], zero fill
  input  wire logic        s_tuser,  // target_solid
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // row [9:0], span_start [19:10], span_end [29:20], zero fill
  output logic             m_tuser,  // span_valid
  output logic             m_tlast
);

  logic [4:0]  radius;
  logic [10:0] map_width;
  logic [10:0] map_height;

  fcsg_pkg::state_t state;
  logic [9:0]          cx;
  logic [9:0]          cy;
  logic signed [6:0]   x;
  logic signed [6:0]   y;
  logic signed [9:0]   p;
  logic [1:0]          phase;

  logic signed [6:0]   x_next;
  logic signed [6:0]   y_next;
  logic signed [9:0]   p_next;
  logic signed [9:0]   x_w;
  logic signed [9:0]   y_w;
  logic [4:0]          r_sat;
  logic                out_free;
  logic                accept;
  logic                step_last;

  fcsg_pkg::span_req_t req;
  fcsg_pkg::span_t     span;

  fcsg_span u_span (
    .req  (req),
    .span (span)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 5'd20;
      map_width  <= 11'd512;
      map_height <= 11'd240;
    end else if (cfg_we) begin
      case (cfg_index)
        fcsg_pkg::CFG_RADIUS:     radius     <= cfg_data[4:0];
        fcsg_pkg::CFG_MAP_WIDTH:  map_width  <= cfg_data;
        fcsg_pkg::CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    out_free = !m_tvalid || m_tready;
    s_tready = (state == fcsg_pkg::ST_IDLE) && out_free;
    accept   = s_tvalid && s_tready;
    r_sat    = (radius > 5'(fcsg_pkg::MAX_RADIUS)) ? 5'(fcsg_pkg::MAX_RADIUS) : radius;

    x_w    = {{3{x[6]}}, x};
    y_w    = {{3{y[6]}}, y};
    x_next = x + 7'sd1;
    if (p < 10'sd0) begin
      p_next = p + (x_w <<< 2) + 10'sd6;
      y_next = y;
    end else begin
      p_next = p + ((x_w - y_w) <<< 2) + 10'sd10;
      y_next = y - 7'sd1;
    end
    step_last = (phase == 2'd3) && (y_next < x_next);

    req.cx       = cx;
    req.cy       = cy;
    req.row_ofs  = phase[0] ? x[4:0] : y[4:0];
    req.half_len = phase[0] ? y[4:0] : x[4:0];
    req.row_down = phase[1];
    req.width    = (map_width > fcsg_pkg::MAP_LIMIT) ? fcsg_pkg::MAP_LIMIT : map_width;
    req.height   = (map_height > fcsg_pkg::MAP_LIMIT) ? fcsg_pkg::MAP_LIMIT : map_height;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fcsg_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      phase    <= 2'd0;
    end else begin
      case (state)
        fcsg_pkg::ST_IDLE: begin
          if (accept && !s_tuser) begin
            m_tvalid <= 1'b1;
          end else if (m_tready) begin
            m_tvalid <= 1'b0;
          end
          if (accept && s_tuser) begin
            state <= fcsg_pkg::ST_RUN;
          end
        end
        fcsg_pkg::ST_RUN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            phase    <= phase + 2'd1;
            if (step_last) begin
              state <= fcsg_pkg::ST_IDLE;
            end
          end
        end
        default: state <= fcsg_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cx <= s_tdata[9:0];
      cy <= s_tdata[19:10];
      x  <= 7'sd0;
      y  <= $signed({2'b00, r_sat});
      p  <= 10'sd3 - $signed({4'd0, r_sat, 1'b0});
      if (!s_tuser) begin
        m_tdata <= '0;
        m_tuser <= 1'b0;
        m_tlast <= 1'b1;
      end
    end else if (state == fcsg_pkg::ST_RUN && out_free) begin
      m_tdata <= {2'b00, span.span_end, span.span_start, span.row};
      m_tuser <= span.span_valid;
      m_tlast <= step_last;
      if (phase == 2'd3) begin
        x <= x_next;
        y <= y_next;
        p <= p_next;
      end
    end
  end

`ifndef SYNTH
  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    state == fcsg_pkg::ST_RUN |-> y >= x)
    else $error("circle loop running past its end");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("invalid span carries nonzero data");

  a_blank_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> m_tvalid && m_tlast && state == fcsg_pkg::ST_IDLE)
    else $error("blank center did not give a single final item");
`endif

endmodule
`default_nettype wire
